[design/mma_pkg.sv]
package mma_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int CHAN_W       = 3;
    localparam int DEF_CHANNELS = 5;
    localparam int DEF_WINDOW   = 16;

    // width that holds WINDOW full-scale samples
    function automatic int sum_w(input int window);
        return $clog2(window * ((1 << SAMPLE_W) - 1) + 1);
    endfunction

    // width that holds 0..WINDOW
    function automatic int fill_w(input int window);
        return $clog2(window + 1);
    endfunction

    // index width for n entries, at least one bit
    function automatic int ptr_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // packed per-channel state word: {sum, fill, position}
    function automatic int st_w(input int window);
        return sum_w(window) + fill_w(window) + ptr_w(window);
    endfunction

endpackage

[design/mma_ring_mem.sv]
module mma_ring_mem #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW   = mma_pkg::DEF_WINDOW
) (
    input  logic                                           i_clk,
    input  logic                                           i_en,
    input  logic [mma_pkg::ptr_w(CHANNELS*WINDOW)-1:0]     i_addr,
    input  logic [mma_pkg::SAMPLE_W-1:0]                   i_wdata,
    output logic [mma_pkg::SAMPLE_W-1:0]                   o_rdata
);
    import mma_pkg::*;

    localparam int DEPTH = CHANNELS * WINDOW;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    // read-first: the old sample comes out while the new one goes in
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata      <= mem[i_addr];
            mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/mma_state_mem.sv]
module mma_state_mem #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW   = mma_pkg::DEF_WINDOW
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd_en,
    input  logic [mma_pkg::ptr_w(CHANNELS)-1:0]    i_rd_idx,
    output logic [mma_pkg::st_w(WINDOW)-1:0]       o_rd_data,
    input  logic                                   i_wr_en,
    input  logic [mma_pkg::ptr_w(CHANNELS)-1:0]    i_wr_idx,
    input  logic [mma_pkg::st_w(WINDOW)-1:0]       i_wr_data
);
    import mma_pkg::*;

    localparam int ST_W = st_w(WINDOW);

    logic [ST_W-1:0]     mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    logic [ST_W-1:0]     r_rd_data;

    // per-channel written flag; an unwritten channel reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_idx] ? mem[i_rd_idx] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/mma_div.sv]
module mma_div #(
    parameter int WINDOW = mma_pkg::DEF_WINDOW
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [mma_pkg::sum_w(WINDOW)-1:0]    i_dividend,
    input  logic [mma_pkg::fill_w(WINDOW)-1:0]   i_divisor,
    output logic                                 o_done,
    output logic [mma_pkg::SAMPLE_W-1:0]         o_quotient
);
    import mma_pkg::*;

    localparam int FW = fill_w(WINDOW);
    localparam int CW = $clog2(SAMPLE_W);
    localparam logic [CW-1:0] LAST = CW'(SAMPLE_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [FW-1:0]       r_rem;
    logic [FW-1:0]       r_dvs;
    logic [SAMPLE_W-1:0] r_lo;
    logic [SAMPLE_W-1:0] r_quo;
    logic [FW:0]         trial;
    logic [FW:0]         diff;
    logic                ge;

    // restoring division, one quotient bit per cycle; the mean never
    // exceeds full scale, so the upper dividend bits start below the divisor
    assign trial = {r_rem, r_lo[SAMPLE_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST) && !i_start;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= FW'(i_dividend >> SAMPLE_W);
            r_lo  <= i_dividend[SAMPLE_W-1:0];
            r_dvs <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[FW-1:0] : trial[FW-1:0];
            r_lo  <= {r_lo[SAMPLE_W-2:0], 1'b0};
            r_quo <= {r_quo[SAMPLE_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[design/multichannel_moving_average.sv]
// Multichannel moving average filter.
// Input channel (i_in_valid / o_in_ready): one converter sample per item,
// tagged with its channel number. Output channel (o_out_valid /
// i_out_ready): one item per input item, the channel and the truncated mean
// of that channel's last WINDOW samples (of all samples so far during
// warm-up). A channel number of CHANNELS or above changes nothing and
// returns a mean of zero.
// Items are processed one at a time; a new item is taken only once the
// previous result has gone into the output register. An item passes
// through the read-modify-write of the channel state and sample ring
// memories, then the bit-serial divider, one restoring quotient bit per
// cycle; an out-of-range channel skips both.
// Reset clears the per-channel sums, fill counts and write positions at
// once (written flags per channel); the sample ring needs no clearing.
// A stalled receiver holds the result in the output register; the block
// still accepts the next item and works on it, and only waits before
// handing over the following result.
module multichannel_moving_average #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW   = mma_pkg::DEF_WINDOW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mma_pkg::CHAN_W-1:0]    i_channel,
    input  logic [mma_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mma_pkg::CHAN_W-1:0]    o_out_channel,
    output logic [mma_pkg::SAMPLE_W-1:0]  o_average
);
    import mma_pkg::*;

    localparam int SW   = sum_w(WINDOW);
    localparam int FW   = fill_w(WINDOW);
    localparam int PW   = ptr_w(WINDOW);
    localparam int IW   = ptr_w(CHANNELS);
    localparam int AW   = ptr_w(CHANNELS * WINDOW);
    localparam int ST_W = st_w(WINDOW);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
    localparam logic [2:0] S_RD   = 3'd1;  // channel state valid, ring access
    localparam logic [2:0] S_UPD  = 3'd2;  // old sample valid, write state back
    localparam logic [2:0] S_DIV  = 3'd3;  // divider running
    localparam logic [2:0] S_DONE = 3'd4;  // wait for output register

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [IW-1:0]       r_idx;
    logic [CHAN_W-1:0]   r_chan;
    logic [SAMPLE_W-1:0] r_samp;
    logic                r_oor;
    logic                r_out_valid;
    logic [CHAN_W-1:0]   r_out_chan;
    logic [SAMPLE_W-1:0] r_avg;

    logic                in_acc;
    logic                in_range;
    logic                out_free;
    logic                load_out;

    logic [ST_W-1:0]     st_rd_data;
    logic [ST_W-1:0]     st_wr_data;
    logic                st_we;
    logic [SW-1:0]       cur_sum;
    logic [FW-1:0]       cur_fill;
    logic [PW-1:0]       cur_pos;
    logic [PW-1:0]       pos_c;
    logic                full;
    logic [SW-1:0]       new_sum;
    logic [FW-1:0]       new_fill;
    logic [PW-1:0]       new_pos;

    logic                ring_en;
    logic [AW-1:0]       ring_addr;
    logic [SAMPLE_W-1:0] ring_rdata;

    logic                div_done;
    logic [SAMPLE_W-1:0] div_quo;

    assign in_acc     = i_in_valid && o_in_ready;
    assign in_range   = 32'(i_channel) < CHANNELS;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign load_out   = (r_state == S_DONE) && out_free;

    // channel state word: {running sum, fill count, write position}
    assign cur_sum  = st_rd_data[ST_W-1 -: SW];
    assign cur_fill = st_rd_data[PW +: FW];
    assign cur_pos  = st_rd_data[PW-1:0];

    assign pos_c = (32'(cur_pos) >= WINDOW) ? '0 : cur_pos;
    assign full  = 32'(cur_fill) >= WINDOW;

    // ring slot of this channel; the sample is written as the old one is read
    assign ring_en   = (r_state == S_RD);
    assign ring_addr = AW'(32'(r_idx) * WINDOW + 32'(pos_c));

    // once full, the overwritten sample leaves the sum
    assign new_sum  = cur_sum + SW'(r_samp) - (full ? SW'(ring_rdata) : '0);
    assign new_fill = full ? cur_fill : cur_fill + 1'b1;
    assign new_pos  = (32'(pos_c) == WINDOW - 1) ? '0 : pos_c + 1'b1;

    assign st_we      = (r_state == S_UPD);
    assign st_wr_data = {new_sum, new_fill, new_pos};

    mma_state_mem #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc && in_range),
        .i_rd_idx  (IW'(i_channel)),
        .o_rd_data (st_rd_data),
        .i_wr_en   (st_we),
        .i_wr_idx  (r_idx),
        .i_wr_data (st_wr_data)
    );

    mma_ring_mem #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_ring_mem (
        .i_clk   (i_clk),
        .i_en    (ring_en),
        .i_addr  (ring_addr),
        .i_wdata (r_samp),
        .o_rdata (ring_rdata)
    );

    // divisor is the fill count after this sample, never zero
    mma_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (st_we),
        .i_dividend (new_sum),
        .i_divisor  (new_fill),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = in_range ? S_RD : S_DONE;
                end
            end
            S_RD:   n_state = S_UPD;
            S_UPD:  n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_idx  <= IW'(i_channel);
            r_chan <= i_channel;
            r_samp <= i_sample;
            r_oor  <= !in_range;
        end
        if (load_out) begin
            r_out_chan <= r_chan;
            r_avg      <= r_oor ? '0 : div_quo;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_chan;
    assign o_average     = r_avg;

`ifndef SYNTHESIS
    a_oor_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !in_range) |=> (r_state == S_DONE))
        else $error("out-of-range channel did not bypass the update");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> ((new_fill != '0) && (32'(new_fill) <= WINDOW)))
        else $error("fill count written back out of range");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (32'(r_out_chan) >= CHANNELS)) |-> (r_avg == '0))
        else $error("out-of-range channel gave a nonzero mean");
`endif

endmodule

[tb/sv/multichannel_moving_average_test.sv]
module multichannel_moving_average_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mma_pkg::*;

    // Block configuration used by this bench; must match the uut parameters
    localparam int NCH = DEF_CHANNELS;
    localparam int WIN = DEF_WINDOW;

    // Random sample count and the settle time after the last result
    localparam int RANDOM_SAMPLES = 425;
    localparam int DRAIN_CYCLES   = 40;

    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic [SAMPLE_W-1:0] smp_t;

    // One item on the input side: a sample tagged with its channel
    typedef struct packed {
        chan_t channel;
        smp_t  sample;
    } sample_item_t;

    // One item on the output side: the channel and its filtered value
    typedef struct packed {
        chan_t channel;
        smp_t  average;
    } mean_item_t;

    // Receiver behavior; each one holds for a random stretch of cycles
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY
    } ready_mode_t;

    logic i_clk;
    logic i_rst_n    = 1'b0;
    logic in_valid   = 1'b0;
    chan_t in_channel = '0;
    smp_t  in_sample  = '0;
    logic out_ready  = 1'b0;

    logic  o_in_ready;
    logic  o_out_valid;
    chan_t o_out_channel;
    smp_t  o_average;

    multichannel_moving_average #(
        .CHANNELS(NCH),
        .WINDOW  (WIN)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_channel    (in_channel),
        .i_sample     (in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_channel(o_out_channel),
        .o_average    (o_average)
    );

    // Samples still to be handed to the block, and the filtered values it owes us
    sample_item_t sample_queue[$];
    mean_item_t   owed_means[$];

    int n_errors = 0;

    // Per-channel filter state mirrored by the bench
    smp_t        hist_ring[NCH][WIN];
    int unsigned hist_sum[NCH];
    int unsigned hist_fill[NCH];
    int unsigned hist_pos[NCH];

    // Sender burst/gap bookkeeping
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver stall pattern
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Fold one sample into its channel and return the new truncated mean.
    // An out-of-range channel leaves every channel alone and gives zero.
    function automatic smp_t fold_channel_sample(input chan_t ch, input smp_t s);
        int unsigned p;
        if (ch >= NCH)
            return '0;
        p = hist_pos[ch];
        if (hist_fill[ch] >= WIN)
            hist_sum[ch] -= hist_ring[ch][p];   // oldest sample drops out
        else
            hist_fill[ch] += 1;                 // warm-up: divisor grows
        hist_ring[ch][p] = s;
        hist_sum[ch] += s;
        hist_pos[ch] = (p + 1 >= WIN) ? 0 : p + 1;
        return smp_t'(hist_sum[ch] / hist_fill[ch]);
    endfunction

    task automatic queue_sample(input int ch, input int s);
        sample_item_t it;
        it.channel = chan_t'(ch);
        it.sample  = smp_t'(s);
        sample_queue.push_back(it);
    endtask

    // Sender: pops from sample_queue, works in bursts separated by gaps.
    // valid is computed once per edge so it never gets two NBAs in a step.
    always @(posedge i_clk) begin : feed_samples
        logic         fire;
        logic         nxt_valid;
        sample_item_t nxt;
        mean_item_t   owed;
        fire        = in_valid && o_in_ready;
        nxt_valid   = in_valid && !fire;
        nxt.channel = in_channel;
        nxt.sample  = in_sample;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (fire) begin
                owed.channel = in_channel;
                owed.average = fold_channel_sample(in_channel, in_sample);
                owed_means.push_back(owed);
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_queue.size() > 0) begin
                    nxt       = sample_queue.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // new burst; half the time no gap at all
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0, 1:    gap_left = 0;
                            2:       gap_left = $urandom_range(1, 20);
                            default: gap_left = $urandom_range(20, 60);
                        endcase
                    end
                end
            end
        end
        in_valid   <= nxt_valid;
        in_channel <= nxt.channel;
        in_sample  <= nxt.sample;
    end

    // Receiver: checks each accepted item against the oldest owed mean,
    // then picks ready for the next edge from the current stall mode.
    always @(posedge i_clk) begin : check_means
        mean_item_t want;
        logic       nxt_ready;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (owed_means.size() == 0) begin
                $display("%0t: unexpected item: channel %0d average %0d",
                         $time, o_out_channel, o_average);
                n_errors++;
            end else begin
                want = owed_means.pop_front();
                if (o_out_channel !== want.channel) begin
                    $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                             $time, want.channel, o_out_channel);
                    n_errors++;
                end
                if (o_average !== want.average) begin
                    $display("%0t: average mismatch (ch %0d): expected %0d, actual %0d",
                             $time, want.channel, want.average, o_average);
                    n_errors++;
                end
            end
        end
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS: nxt_ready = 1'b1;
            READY_MOSTLY: nxt_ready = ($urandom_range(0, 3) != 0);
            default:      nxt_ready = ($urandom_range(0, 7) == 0);
        endcase
        if (!i_rst_n)
            nxt_ready = 1'b0;
        out_ready <= nxt_ready;
    end

    // Stimulus and end of run
    initial begin : run_test
        int n_rand;
        int ch;
        int base;
        int len;
        int s;

        for (int c = 0; c < NCH; c++) begin
            hist_sum[c]  = 0;
            hist_fill[c] = 0;
            hist_pos[c]  = 0;
        end

        // Directed part.
        // Out-of-range channels, every one of them, with extreme and alternating-bit samples.
        queue_sample(7, 4095);
        queue_sample(5, 0);
        queue_sample(6, 12'hAAA);
        // Warm-up: first sample alone sets the mean, then divisor of two.
        queue_sample(0, 0);
        queue_sample(0, 4095);
        queue_sample(3, 12'h555);
        // Fill channel 4 at full scale (largest sum), with an out-of-range
        // item in the middle that must leave it untouched, then wrap.
        for (int i = 0; i < WIN; i++) begin
            queue_sample(4, 4095);
            if (i == WIN / 2)
                queue_sample(6, 4095);
        end
        queue_sample(4, 0);

        // Random part: mostly realistic traffic on valid channels,
        // plus saturated runs that fill and wrap rings, drift and noise.
        n_rand = 0;
        while (n_rand < RANDOM_SAMPLES) begin
            case ($urandom_range(0, 9))
                0: begin
                    // bad channel
                    queue_sample($urandom_range(NCH, 7), $urandom_range(0, 4095));
                    n_rand++;
                end
                1, 2: begin
                    // long run at an extreme or alternating extremes
                    ch  = $urandom_range(0, NCH - 1);
                    len = $urandom_range(WIN, WIN + 8);
                    base = $urandom_range(0, 2);
                    for (int i = 0; i < len; i++) begin
                        case (base)
                            0:       s = 4095;
                            1:       s = 0;
                            default: s = (i % 2) ? 4095 : 0;
                        endcase
                        queue_sample(ch, s);
                    end
                    n_rand += len;
                end
                3, 4: begin
                    // slow drift around a level, channels interleaved
                    base = $urandom_range(0, 4095);
                    len  = $urandom_range(5, 25);
                    for (int i = 0; i < len; i++) begin
                        s = base + $urandom_range(0, 120) - 60;
                        if (s < 0)
                            s = 0;
                        if (s > 4095)
                            s = 4095;
                        queue_sample($urandom_range(0, NCH - 1), s);
                    end
                    n_rand += len;
                end
                default: begin
                    queue_sample($urandom_range(0, NCH - 1), $urandom_range(0, 4095));
                    n_rand++;
                end
            endcase
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_queue.size() != 0 || in_valid)
            @(posedge i_clk);
        while (owed_means.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (owed_means.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, owed_means.size());
            n_errors++;
        end

        if (n_errors == 0) begin
            $display("[multichannel_moving_average] OK");
        end else begin
            $display("[multichannel_moving_average] ERROR");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("[multichannel_moving_average] ERROR");
        $finish;
    end

endmodule
